// ----- sv/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character lookup for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ILLEGAL = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_PADS    = 3'd3,
    ST_AFTER   = 3'd4,
    ST_EARLY   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       msg_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;
    status_t    status;
  } result_t;

  // One queued unit of work: either a decoded group (1..3 bytes) or a
  // single status-only result.
  typedef struct packed {
    logic        is_data;
    logic [23:0] word;
    logic [1:0]  count;
    logic        msg_end;
    status_t     status;
  } job_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t char_to_sextet(input logic [7:0] c);
    sextet_t r;
    r.bad   = 1'b0;
    r.value = '0;
    case (c) inside
      [8'h41:8'h5A]: r.value = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.value = 6'(c - 8'h61) + SEXTET_LOWER_BASE;
      [8'h30:8'h39]: r.value = 6'(c - 8'h30) + SEXTET_DIGIT_BASE;
      PLUS_CHAR:     r.value = SEXTET_PLUS;
      SLASH_CHAR:    r.value = SEXTET_SLASH;
      default:       r.bad   = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, tracks group state and emits one job per
// character that causes results.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic              clk,
  input  logic              rst,
  input  b64d_pkg::in_item_t item,
  input  logic              accept,
  output logic              job_valid,
  output b64d_pkg::job_t    job
);
  import b64d_pkg::*;

  logic [17:0] sextet_acc, sextet_acc_next;
  logic [1:0]  group_pos, group_pos_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        discarding, discarding_next;

  sextet_t sx;
  logic    is_pad;
  logic    err;
  status_t err_code;
  logic [5:0] s;

  always_comb begin
    sx = char_to_sextet(item.in_char);
    is_pad = (item.in_char == PAD_CHAR);
    sextet_acc_next = sextet_acc;
    group_pos_next  = group_pos;
    pad_count_next  = pad_count;
    discarding_next = discarding;
    job_valid       = 1'b0;
    job             = '0;
    err             = 1'b0;
    err_code        = ST_OK;
    s               = sx.value;

    if (discarding) begin
      if (item.msg_end) begin
        discarding_next = 1'b0;
        sextet_acc_next = '0;
        group_pos_next  = '0;
        pad_count_next  = '0;
        job_valid       = 1'b1;
        job.msg_end     = 1'b1;
        job.count       = 2'd1;
        job.status      = ST_OK;
      end
    end else begin
      if (!is_pad && sx.bad) begin
        err = 1'b1;
        err_code = ST_ILLEGAL;
      end else if (is_pad) begin
        s = '0;
        if (group_pos == 2'd0 && pad_count != 2'd0) begin
          err = 1'b1;
          err_code = ST_PADS;
        end else if (group_pos < 2'd2) begin
          err = 1'b1;
          err_code = ST_EARLY;
        end else begin
          pad_count_next = pad_count + 2'd1;
        end
      end else if (pad_count != 2'd0) begin
        err = 1'b1;
        err_code = ST_AFTER;
      end

      if (!err) begin
        if (group_pos != 2'd3) begin
          sextet_acc_next = {sextet_acc[11:0], s};
          group_pos_next  = group_pos + 2'd1;
          if (item.msg_end) begin
            err = 1'b1;
            err_code = ST_LENGTH;
          end
        end else begin
          job_valid       = 1'b1;
          job.is_data     = 1'b1;
          job.word        = {sextet_acc, s};
          job.count       = 2'd3 - pad_count_next;
          job.msg_end     = item.msg_end;
          sextet_acc_next = '0;
          group_pos_next  = '0;
          if (item.msg_end) pad_count_next = '0;
        end
      end

      if (err) begin
        sextet_acc_next = '0;
        group_pos_next  = '0;
        pad_count_next  = '0;
        discarding_next = !item.msg_end;
        job_valid       = 1'b1;
        job.is_data     = 1'b0;
        job.count       = 2'd1;
        job.msg_end     = item.msg_end;
        job.status      = err_code;
      end
    end

    // hold state unless a character is taken
    if (!accept) job_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_acc <= '0;
      group_pos  <= '0;
      pad_count  <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      sextet_acc <= sextet_acc_next;
      group_pos  <= group_pos_next;
      pad_count  <= pad_count_next;
      discarding <= discarding_next;
    end
  end

endmodule

// ----- sv/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Small job FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64d_pkg::job_t wr_data,
  input  logic           rd_en,
  output b64d_pkg::job_t rd_data,
  output logic           full,
  output logic           empty
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (do_rd) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (do_wr && !do_rd)      count <= count + CW'(1);
      else if (do_rd && !do_wr) count <= count - CW'(1);
    end
  end

endmodule

// ----- sv/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Holds one job and plays out its results one transaction at a time.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  b64d_pkg::job_t    q_data,
  output logic              q_pop,
  output b64d_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import b64d_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       take;

  assign last  = (idx + 2'd1 == cur.count);
  assign take  = pop && cur_valid;
  assign q_pop = !q_empty && (!cur_valid || (take && last));
  assign empty = !cur_valid;

  always_comb begin
    result = '0;
    if (cur.is_data) begin
      case (idx)
        2'd0:    result.out_byte = cur.word[23:16];
        2'd1:    result.out_byte = cur.word[15:8];
        default: result.out_byte = cur.word[7:0];
      endcase
      result.byte_valid   = 1'b1;
      result.run_last     = last;
      result.message_done = last && cur.msg_end;
      result.status       = ST_OK;
    end else begin
      result.run_last     = 1'b1;
      result.message_done = cur.msg_end;
      result.status       = cur.status;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      // advance within the job, or drop it when done
      if (last) cur_valid <= 1'b0;
      else      idx <= idx + 2'd1;
    end
  end

endmodule

// ----- sv/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Base64 text decoder: one character in per transaction, up to three
// result transactions per character.
//
//   channel | handshake     | payload
//   --------+---------------+------------------------------------------
//   input   | push / full   | item   : in_char, msg_end
//   result  | pop / empty   | result : out_byte, byte_valid, run_last,
//           |               |          message_done, status
//
// One character is taken per cycle while the job queue has room.
// Results leave one per cycle from the back register while pop is held; a
// four-character group yields up to three results, set by that single result port.
// A completing character's job is written into the queue and then loaded into
// the back register, where its first result is on the ports and can be popped.
// Reset clears group state, queue pointers and count, and the back register's valid flag.
// A stalled result side fills the queue (QUEUE_DEPTH jobs), then raises full.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  b64d_pkg::in_item_t item,
  output logic              empty,
  input  logic              pop,
  output b64d_pkg::result_t result
);
  import b64d_pkg::*;

  logic accept;
  logic job_valid;
  job_t job;
  job_t q_data;
  logic q_empty;
  logic q_pop;

  assign accept = push && !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .accept    (accept),
    .job_valid (job_valid),
    .job       (job)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_data (job),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  b64d_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  a_status_no_byte : assert property (@(posedge clk) disable iff (rst)
    !empty && result.byte_valid |-> result.status == ST_OK)
    else $error("data result carries an error status");

  a_status_is_last : assert property (@(posedge clk) disable iff (rst)
    !empty && !result.byte_valid |-> result.run_last && result.out_byte == 8'd0)
    else $error("status-only result is not the last of its transaction");

  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    !empty && result.message_done |-> result.run_last)
    else $error("message end on a result that is not last");

  a_reset_clear : assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queue not clear after reset");

endmodule
